// ===== src/rcoi_pkg.sv =====
// ----------------------------------------------------------------------------
// rcoi_pkg
// Types and constants shared by the object index block.
// ----------------------------------------------------------------------------
package rcoi_pkg;

  localparam int POOL_BYTES_DEF  = 65536;
  localparam int MAX_OBJECTS_DEF = 64;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_RETRIEVE = 2'd1,
    OP_ADD      = 2'd2,
    OP_DROP     = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [16:0] obj_size;
    logic [15:0] handle;
  } in_item_t;

  typedef struct packed {
    logic [15:0] new_handle;
    logic        found;
    logic        buffer_sel;
    logic [15:0] obj_offset;
    logic        did_compact;
    logic [6:0]  live_objects;
    logic [16:0] bytes_used;
    logic [16:0] bytes_freed;
  } out_item_t;

  // one index entry as held in memory
  typedef struct packed {
    logic [15:0] handle;
    logic [16:0] size;
    logic [15:0] offset;
    logic [15:0] refs;
  } entry_t;

endpackage

// ===== src/refcount_compacting_object_index_top.sv =====
// ----------------------------------------------------------------------------
// refcount_compacting_object_index_top
// Reference counted bump allocator index with a compacting collector.
// ----------------------------------------------------------------------------
// One item at a time. The entries sit in a memory with one write port and a
// registered read port, and a sequencer walks it one entry at a time, through
// a read state and a check state for each. Retrieve, add and drop scan from
// entry 0 until the handle matches, or over all entries in use for a miss.
// An insert that fits is written at once; one that does not fit compacts
// first and then tries again. The sequencer returns to idle before the next
// item is taken. The finished result sits in an output register until taken.
module refcount_compacting_object_index_top #(
  parameter int POOL_BYTES  = rcoi_pkg::POOL_BYTES_DEF,
  parameter int MAX_OBJECTS = rcoi_pkg::MAX_OBJECTS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  rcoi_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rcoi_pkg::out_item_t out_data
);
  import rcoi_pkg::*;

  localparam int AW = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
  localparam int CW = $clog2(MAX_OBJECTS + 1);
  localparam int BW = $clog2(POOL_BYTES + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_CHK, S_INS, S_DONE
  } state_t;

  state_t        state;
  entry_t        mem [MAX_OBJECTS];
  entry_t        rd_data;
  logic [AW-1:0] rd_addr;
  logic          mem_we;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;

  in_item_t      req;
  logic [CW-1:0] entries_used;
  logic [CW-1:0] rptr;
  logic [CW-1:0] wptr;
  logic [15:0]   next_handle;
  logic          active_buffer;
  logic [BW-1:0] used_bytes;
  logic [BW-1:0] off_acc;
  logic [BW-1:0] gone;
  logic          compacting;
  out_item_t     res;

  // entry memory
  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  // fit test against current totals
  function automatic logic fits_f(input logic [16:0] sz, input logic [CW-1:0] n,
                                  input logic [BW-1:0] ub);
    logic [BW:0] room;
    room = (BW+1)'(POOL_BYTES) - {1'b0, ub};
    return (sz != '0) && (n < CW'(MAX_OBJECTS)) && (ub <= BW'(POOL_BYTES))
           && ({{(BW+1){1'b0}}, sz} <= {17'b0, room});
  endfunction

  logic          fit_now;
  logic [BW-1:0] new_off;
  logic [15:0]   inc_handle;
  assign fit_now    = fits_f(req.obj_size, entries_used, used_bytes);
  assign inc_handle = (next_handle == 16'hFFFF) ? 16'd1 : next_handle + 16'd1;

  // memory port control
  always_comb begin
    mem_we  = 1'b0;
    wr_addr = rptr[AW-1:0];
    wr_data = rd_data;
    rd_addr = rptr[AW-1:0];
    new_off = off_acc + BW'(rd_data.size);
    if (state == S_CHK) begin
      if (compacting) begin
        wr_addr        = wptr[AW-1:0];
        wr_data.offset = 16'(off_acc);
        mem_we         = (rd_data.refs != '0);
      end else if (rd_data.handle == req.handle) begin
        mem_we = (req.opcode == OP_ADD && rd_data.refs != COUNT_MAX) ||
                 (req.opcode == OP_DROP && rd_data.refs != '0);
        wr_data.refs = (req.opcode == OP_ADD) ? rd_data.refs + 16'd1
                                              : rd_data.refs - 16'd1;
      end
    end else if (state == S_INS) begin
      wr_addr = entries_used[AW-1:0];
      wr_data = '{handle: next_handle, size: req.obj_size,
                  offset: 16'(used_bytes), refs: 16'd1};
      mem_we  = fit_now;
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_DONE);
  assign out_data  = res;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      entries_used  <= '0;
      next_handle   <= 16'd1;
      active_buffer <= 1'b0;
      used_bytes    <= '0;
      rptr          <= '0;
      compacting    <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            req        <= in_data;
            res        <= '0;
            rptr       <= '0;
            wptr       <= '0;
            off_acc    <= '0;
            gone       <= '0;
            compacting <= 1'b0;
            state      <= (in_data.opcode == OP_INSERT) ? S_INS : S_RD;
          end
        end
        S_INS: begin
          if (!fit_now && !compacting && !res.did_compact) begin
            compacting      <= 1'b1;
            res.did_compact <= 1'b1;
            state           <= S_RD;
          end else begin
            if (fit_now) begin
              entries_used   <= entries_used + CW'(1);
              used_bytes     <= used_bytes + BW'(req.obj_size);
              res.new_handle <= next_handle;
              res.buffer_sel <= active_buffer;
              res.obj_offset <= 16'(used_bytes);
              res.bytes_used <= 17'(used_bytes + BW'(req.obj_size));
              next_handle    <= inc_handle;
            end else begin
              res.bytes_used <= 17'(used_bytes);
            end
            state <= S_DONE;
          end
        end
        S_RD: begin
          // end of walk
          if (rptr >= entries_used) begin
            if (compacting) begin
              entries_used     <= wptr;
              used_bytes       <= off_acc;
              active_buffer    <= ~active_buffer;
              res.live_objects <= 7'(wptr);
              res.bytes_freed  <= 17'(gone);
              compacting       <= 1'b0;
              state            <= S_INS;
            end else begin
              res.bytes_used <= 17'(used_bytes);
              state          <= S_DONE;
            end
          end else begin
            state <= S_CHK;
          end
        end
        S_CHK: begin
          rptr  <= rptr + CW'(1);
          state <= (!compacting && rd_data.handle == req.handle) ? S_DONE : S_RD;
          if (compacting) begin
            if (rd_data.refs == '0) begin
              gone <= gone + BW'(rd_data.size);
            end else begin
              off_acc <= new_off;
              wptr    <= wptr + CW'(1);
            end
          end else if (rd_data.handle == req.handle) begin
            res.found      <= 1'b1;
            res.buffer_sel <= active_buffer;
            res.obj_offset <= rd_data.offset;
            res.bytes_used <= 17'(used_bytes);
          end
        end
        S_DONE: begin
          if (out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== src/rcoi_checker.sv =====
// ----------------------------------------------------------------------------
// rcoi_checker
// Port level checks for the object index block.
// ----------------------------------------------------------------------------
module rcoi_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input rcoi_pkg::out_item_t out_data
);
  import rcoi_pkg::*;

  // a result waiting holds steady
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // never ready for input while a result is pending
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready while result pending");

  // busy right after taking an item
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready again right after an item");

  // insert gives no found flag, lookup gives no handle
  a_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.found && out_data.new_handle != 16'd0))
    else $error("result mixes insert and lookup");

  // compaction fields only with compaction
  a_comp: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.did_compact |->
      out_data.live_objects == 7'd0 && out_data.bytes_freed == 17'd0)
    else $error("compaction figures without compaction");

endmodule

bind refcount_compacting_object_index_top rcoi_checker u_rcoi_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
